// ----- src/minv4x4_pkg.sv -----
// Shared types, defaults and term sequencing tables for the 4x4 matrix inverse unit.
package minv4x4_pkg;

    localparam int DEF_ELEMENT_WIDTH = 32;
    localparam int DEF_FRAC_BITS     = 16;
    localparam int MATRIX_WORDS      = 16;
    localparam int NUM_MINORS        = 12;

    typedef enum logic [1:0] {
        PH_MINOR,
        PH_DET,
        PH_ADJ
    } t_phase;

    // one product term: operand sources, sign and end of sum
    typedef struct packed {
        logic       a_elem;
        logic [3:0] a_idx;
        logic       b_elem;
        logic [3:0] b_idx;
        logic       sub;
        logic       last;
    } t_term;

    function automatic t_term term_desc(t_phase ph, logic [3:0] k, logic [2:0] t);
        t_term      d;
        logic [2:0] j;
        logic [3:0] base;
        logic [1:0] pa;
        logic [1:0] pb;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] oc;
        logic [2:0] ms;
        d    = '0;
        j    = '0;
        base = '0;
        pa   = '0;
        pb   = '0;
        row  = k[3:2];
        col  = k[1:0];
        oc   = '0;
        ms   = '0;
        case (ph)
            PH_MINOR: begin
                if (k < 4'd6) begin
                    base = 4'd0;
                    j    = k[2:0];
                end else begin
                    base = 4'd8;
                    j    = 3'(k - 4'd6);
                end
                case (j)
                    3'd0: begin pa = 2'd0; pb = 2'd1; end
                    3'd1: begin pa = 2'd0; pb = 2'd2; end
                    3'd2: begin pa = 2'd0; pb = 2'd3; end
                    3'd3: begin pa = 2'd1; pb = 2'd2; end
                    3'd4: begin pa = 2'd1; pb = 2'd3; end
                    default: begin pa = 2'd2; pb = 2'd3; end
                endcase
                d.a_elem = 1'b1;
                d.b_elem = 1'b1;
                if (t == 3'd0) begin
                    d.a_idx = base + {2'b00, pa};
                    d.b_idx = base + 4'd4 + {2'b00, pb};
                    d.sub   = 1'b0;
                end else begin
                    d.a_idx = base + 4'd4 + {2'b00, pa};
                    d.b_idx = base + {2'b00, pb};
                    d.sub   = 1'b1;
                end
                d.last = (t == 3'd1);
            end
            PH_DET: begin
                d.a_idx = {1'b0, t};
                d.b_idx = 4'd11 - {1'b0, t};
                d.sub   = (t == 3'd1) || (t == 3'd4);
                d.last  = (t == 3'd5);
            end
            PH_ADJ: begin
                oc = (t[1:0] < row) ? t[1:0] : 2'(t[1:0] + 2'd1);
                case ({row, t[1:0]})
                    4'b00_00: ms = 3'd5;
                    4'b00_01: ms = 3'd4;
                    4'b00_10: ms = 3'd3;
                    4'b01_00: ms = 3'd5;
                    4'b01_01: ms = 3'd2;
                    4'b01_10: ms = 3'd1;
                    4'b10_00: ms = 3'd4;
                    4'b10_01: ms = 3'd2;
                    4'b10_10: ms = 3'd0;
                    4'b11_00: ms = 3'd3;
                    4'b11_01: ms = 3'd1;
                    default:  ms = 3'd0;
                endcase
                d.a_elem = 1'b1;
                d.a_idx  = {col ^ 2'd1, oc};
                d.b_idx  = ((col < 2'd2) ? 4'd6 : 4'd0) + {1'b0, ms};
                d.sub    = (t == 3'd1) ^ row[0] ^ col[0];
                d.last   = (t == 3'd2);
            end
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

// ----- src/minv4x4_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module minv4x4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/matrix_inverse_4x4_unit.sv -----
// Top level: 4x4 fixed-point matrix inverse by cofactors, serial multiply and divide.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  load    | start, busy, i_element_value              | in (busy: out)
//  result  | o_valid, o_inverse_value, o_element_index, | out
//          | o_last_element, o_singular, o_saturated   |
//
// Load words are written while the unit is idle; after the sixteenth the unit is busy while
// 78 product terms run through one bit-serial multiplier and each of the 16 results through
// a restoring divider.
// Synchronous active-low reset clears the load count and the sequencer.
// Results are strobed for one cycle by o_valid; the receiver cannot stall them.
module matrix_inverse_4x4_unit #(
    parameter int ELEMENT_WIDTH = minv4x4_pkg::DEF_ELEMENT_WIDTH,
    parameter int FRAC_BITS     = minv4x4_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic        [31:0] i_element_value,
    output logic               busy,
    output logic               o_valid,
    output logic signed [31:0] o_inverse_value,
    output logic        [3:0]  o_element_index,
    output logic               o_last_element,
    output logic               o_singular,
    output logic               o_saturated
);

    localparam int W   = ELEMENT_WIDTH;
    localparam int MW  = 2 * W + 1;
    localparam int AW  = 4 * W + 6;
    localparam int QB  = W;
    localparam int DVW = AW + 2 * FRAC_BITS + QB + 1;
    localparam int MCW = $clog2(MW);
    localparam int DCW = $clog2(QB);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH_A,
        S_FETCH_B,
        S_CAP_B,
        S_MUL,
        S_ACC,
        S_NEXT,
        S_DIV_CHK,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [3:0]            r_load_count;
    minv4x4_pkg::t_phase   r_phase;
    logic [3:0]            r_k;
    logic [2:0]            r_t;
    logic [MW-1:0]         r_ma;
    logic                  r_sa;
    logic                  r_pneg;
    logic [2*MW-1:0]       r_p;
    logic [MCW-1:0]        r_mcnt;
    logic signed [AW-1:0]  r_acc;
    logic [MW-1:0]         r_minor [minv4x4_pkg::NUM_MINORS];
    logic [AW-1:0]         r_adet;
    logic                  r_dneg;
    logic                  r_dzero;
    logic [DVW-1:0]        r_rem;
    logic [DVW-1:0]        r_ds;
    logic [W-1:0]          r_q;
    logic [DCW-1:0]        r_dcnt;
    logic                  r_neg;
    logic                  r_ovf;

    minv4x4_pkg::t_term    desc;
    logic                  ram_we;
    logic [3:0]            ram_raddr;
    logic [W-1:0]          ram_rdata;
    logic [3:0]            minor_idx;
    logic [MW-1:0]         minor_rd;
    logic [MW-1:0]         opnd;
    logic [MW-1:0]         opnd_abs;
    logic [MW:0]           mul_sum;
    logic [AW-1:0]         prod_ext;
    logic [AW-1:0]         acc_base;
    logic [AW-1:0]         acc_next;
    logic [AW-1:0]         acc_abs;
    logic [DVW-1:0]        num;
    logic [DVW-1:0]        dlim;
    logic                  div_ge;
    logic [W-1:0]          lim;
    logic                  sat;
    logic [W-1:0]          mag;
    logic signed [W:0]     val;

    assign busy   = (r_state != S_IDLE);
    assign ram_we = start && !busy;
    assign desc   = minv4x4_pkg::term_desc(r_phase, r_k, r_t);

    assign ram_raddr = (r_state == S_FETCH_A) ? desc.a_idx : desc.b_idx;
    assign minor_idx = (r_state == S_FETCH_B) ? desc.a_idx : desc.b_idx;
    assign minor_rd  = r_minor[minor_idx];

    always_comb begin
        if ((r_state == S_FETCH_B) ? desc.a_elem : desc.b_elem) begin
            opnd = {{(MW-W){ram_rdata[W-1]}}, ram_rdata};
        end else begin
            opnd = minor_rd;
        end
        opnd_abs = opnd[MW-1] ? (~opnd + 1'b1) : opnd;
    end

    assign mul_sum  = {1'b0, r_p[2*MW-1:MW]} + (r_p[0] ? {1'b0, r_ma} : {(MW+1){1'b0}});
    assign prod_ext = AW'(r_p);
    assign acc_base = (r_t == 3'd0) ? {AW{1'b0}} : r_acc;
    assign acc_next = (desc.sub ^ r_pneg) ? (acc_base - prod_ext) : (acc_base + prod_ext);
    assign acc_abs  = r_acc[AW-1] ? (~r_acc + 1'b1) : r_acc;
    assign num      = DVW'(acc_abs) << (2 * FRAC_BITS);
    assign dlim     = DVW'(r_adet) << QB;
    assign div_ge   = (r_rem >= r_ds);

    assign lim = {1'b1, {(W-1){1'b0}}} - W'(!r_neg);
    assign sat = r_ovf || (r_q > lim);
    assign mag = sat ? lim : r_q;
    assign val = r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    minv4x4_ram #(
        .WIDTH (W),
        .DEPTH (minv4x4_pkg::MATRIX_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_count),
        .i_wdata (W'(i_element_value)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_count <= '0;
            r_phase      <= minv4x4_pkg::PH_MINOR;
            r_k          <= '0;
            r_t          <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_load_count <= r_load_count + 4'd1;
                        if (r_load_count == 4'd15) begin
                            r_phase <= minv4x4_pkg::PH_MINOR;
                            r_k     <= '0;
                            r_t     <= '0;
                            r_state <= S_FETCH_A;
                        end
                    end
                end
                S_FETCH_A: r_state <= S_FETCH_B;
                S_FETCH_B: begin
                    r_ma    <= opnd_abs;
                    r_sa    <= opnd[MW-1];
                    r_state <= S_CAP_B;
                end
                S_CAP_B: begin
                    r_p     <= {{MW{1'b0}}, opnd_abs};
                    r_pneg  <= r_sa ^ opnd[MW-1];
                    r_mcnt  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p    <= {mul_sum, r_p[MW-1:1]};
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == MCW'(MW - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= acc_next;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (!desc.last) begin
                        r_t     <= r_t + 3'd1;
                        r_state <= S_FETCH_A;
                    end else begin
                        r_t <= '0;
                        case (r_phase)
                            minv4x4_pkg::PH_MINOR: begin
                                r_minor[r_k] <= r_acc[MW-1:0];
                                if (r_k == 4'(minv4x4_pkg::NUM_MINORS - 1)) begin
                                    r_phase <= minv4x4_pkg::PH_DET;
                                    r_k     <= '0;
                                end else begin
                                    r_k <= r_k + 4'd1;
                                end
                                r_state <= S_FETCH_A;
                            end
                            minv4x4_pkg::PH_DET: begin
                                r_dzero <= (r_acc == '0);
                                r_dneg  <= r_acc[AW-1];
                                r_adet  <= acc_abs;
                                r_phase <= minv4x4_pkg::PH_ADJ;
                                r_k     <= '0;
                                r_state <= S_FETCH_A;
                            end
                            default: r_state <= S_DIV_CHK;
                        endcase
                    end
                end
                S_DIV_CHK: begin
                    r_neg   <= r_acc[AW-1] ^ r_dneg;
                    r_rem   <= num;
                    r_ds    <= DVW'(r_adet) << (QB - 1);
                    r_ovf   <= (num >= dlim);
                    r_q     <= '0;
                    r_dcnt  <= '0;
                    r_state <= r_dzero ? S_EMIT : S_DIV;
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= r_rem - r_ds;
                    end
                    r_q    <= {r_q[W-2:0], div_ge};
                    r_ds   <= r_ds >> 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCW'(QB - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_valid         <= 1'b1;
                    o_inverse_value <= r_dzero ? 32'sd0 : 32'(val);
                    o_element_index <= r_k;
                    o_last_element  <= (r_k == 4'd15);
                    o_singular      <= r_dzero;
                    o_saturated     <= !r_dzero && sat;
                    if (r_k == 4'd15) begin
                        r_phase <= minv4x4_pkg::PH_MINOR;
                        r_k     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_FETCH_A;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- dv/minv4x4_checker.sv -----
// Checker for the 4x4 matrix inverse unit: watches loads, predicts inverses, compares results.
`timescale 1ns / 1ps
module minv4x4_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic        [31:0] i_element_value,
    input  logic               o_valid,
    input  logic signed [31:0] o_inverse_value,
    input  logic        [3:0]  o_element_index,
    input  logic               o_last_element,
    input  logic               o_singular,
    input  logic               o_saturated,
    output int                 fail_count,
    output int                 pending_words,
    output int                 result_count,
    output int                 singular_count,
    output int                 saturated_count
);

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         index;
        logic               last;
        logic               sing;
        logic               sat;
    } inv_word_t;

    inv_word_t          inverse_q[$];
    logic signed [31:0] loaded[16];
    int                 load_pos;

    // cofactor bookkeeping: remaining columns and the minor each pairs with
    localparam int OTHER_COL[4][3] = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 2}};
    localparam int MINOR_PICK[4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};
    localparam int COL_A[6] = '{0, 0, 0, 1, 1, 2};
    localparam int COL_B[6] = '{1, 2, 3, 2, 3, 3};

    task automatic predict_inverse();
        wide_t     m[16];
        wide_t     top[6];
        wide_t     bot[6];
        wide_t     det;
        wide_t     adet;
        wide_t     adj;
        wide_t     num;
        wide_t     quo;
        wide_t     lim;
        wide_t     res;
        inv_word_t w;
        int        row;
        int        col;
        int        erow;
        logic      neg;
        for (int k = 0; k < 16; k++) m[k] = loaded[k];
        for (int k = 0; k < 6; k++) begin
            top[k] = m[COL_A[k]] * m[4 + COL_B[k]] - m[4 + COL_A[k]] * m[COL_B[k]];
            bot[k] = m[8 + COL_A[k]] * m[12 + COL_B[k]] - m[12 + COL_A[k]] * m[8 + COL_B[k]];
        end
        det = top[0] * bot[5] - top[1] * bot[4] + top[2] * bot[3]
            + top[3] * bot[2] - top[4] * bot[1] + top[5] * bot[0];
        adet = (det < 0) ? -det : det;
        for (int k = 0; k < 16; k++) begin
            row  = k / 4;
            col  = k % 4;
            erow = col ^ 1;
            if (col < 2) begin
                adj = m[erow*4 + OTHER_COL[row][0]] * bot[MINOR_PICK[row][0]]
                    - m[erow*4 + OTHER_COL[row][1]] * bot[MINOR_PICK[row][1]]
                    + m[erow*4 + OTHER_COL[row][2]] * bot[MINOR_PICK[row][2]];
            end else begin
                adj = m[erow*4 + OTHER_COL[row][0]] * top[MINOR_PICK[row][0]]
                    - m[erow*4 + OTHER_COL[row][1]] * top[MINOR_PICK[row][1]]
                    + m[erow*4 + OTHER_COL[row][2]] * top[MINOR_PICK[row][2]];
            end
            if ((row + col) % 2 == 1) adj = -adj;
            w.index = 4'(k);
            w.last  = (k == 15);
            w.sing  = (det == 0);
            w.sat   = 1'b0;
            w.value = '0;
            if (det != 0) begin
                neg = (adj < 0) != (det < 0);
                num = ((adj < 0) ? -adj : adj) <<< 32;
                quo = num / adet;
                lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
                if (quo > lim) begin
                    w.sat = 1'b1;
                    quo   = lim;
                end
                res     = neg ? -quo : quo;
                w.value = res[31:0];
            end
            inverse_q.push_back(w);
        end
    endtask

    assign pending_words = inverse_q.size();

    always @(posedge i_clk) begin
        inv_word_t exp_w;
        if (!i_rst_n) begin
            load_pos = 0;
        end else begin
            if (o_valid) begin
                result_count++;
                if (o_singular) singular_count++;
                if (o_saturated) saturated_count++;
                if (inverse_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: unexpected word idx=%0d val=%h",
                                 o_element_index, o_inverse_value);
                end else begin
                    exp_w = inverse_q.pop_front();
                    if (o_inverse_value !== exp_w.value || o_element_index !== exp_w.index
                        || o_last_element !== exp_w.last || o_singular !== exp_w.sing
                        || o_saturated !== exp_w.sat) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch idx %0d: exp val=%h last=%b sing=%b sat=%b",
                                      " | got idx=%0d val=%h last=%b sing=%b sat=%b"},
                                     exp_w.index, exp_w.value, exp_w.last, exp_w.sing,
                                     exp_w.sat, o_element_index, o_inverse_value,
                                     o_last_element, o_singular, o_saturated);
                    end
                end
            end
            if (start && !busy) begin
                loaded[load_pos] = i_element_value;
                load_pos = (load_pos + 1) % 16;
                if (load_pos == 0) predict_inverse();
            end
        end
    end

    initial begin
        fail_count      = 0;
        result_count    = 0;
        singular_count  = 0;
        saturated_count = 0;
        load_pos        = 0;
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the 4x4 matrix inverse unit: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic        [31:0] i_element_value;
    logic               busy;
    logic               o_valid;
    logic signed [31:0] o_inverse_value;
    logic        [3:0]  o_element_index;
    logic               o_last_element;
    logic               o_singular;
    logic               o_saturated;
    int                 fail_count;
    int                 pending_words;
    int                 result_count;
    int                 singular_count;
    int                 saturated_count;
    int                 idle_pct;
    int                 matrices_sent;
    logic        [31:0] mat[16];

    matrix_inverse_4x4_unit DUT (.*);

    minv4x4_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("FAIL matrix_inverse_4x4_unit");
        $finish;
    end

    // holds start until the word is taken, with optional idle gap first
    task automatic send_word(input logic [31:0] v);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_matrix();
        for (int k = 0; k < 16; k++) send_word(mat[k]);
        matrices_sent++;
    endtask

    function automatic logic [31:0] small_q(input int span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    initial begin
        int kind;
        int r;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_element_value = '0;
        idle_pct        = 0;
        matrices_sent   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tiny diagonal with a negative entry: saturates both ways
        foreach (mat[k]) mat[k] = '0;
        mat[0] = 32'h1; mat[5] = 32'h1; mat[10] = 32'hFFFF_FFFF; mat[15] = 32'h1;
        send_matrix();
        // extremes with repeated rows: singular
        for (int k = 0; k < 16; k++) mat[k] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_matrix();

        for (int n = 0; n < 25; n++) begin
            case ((n / 6) % 4)
                0: idle_pct = 0;
                1: idle_pct = 73;
                2: idle_pct = 0;
                default: idle_pct = 28;
            endcase
            if (n == 12) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_words != 0) @(posedge i_clk);
            end
            kind = $urandom_range(9);
            for (int k = 0; k < 16; k++) begin
                case (kind)
                    0, 1: mat[k] = $urandom;
                    2, 3, 4: mat[k] = small_q(32'h4_0000);
                    5, 6: mat[k] = ((k % 5) == 0 ? 32'h1_0000 : 32'h0) + small_q(32'h4000);
                    7: mat[k] = small_q(4);
                    default: mat[k] = small_q(32'h10_0000);
                endcase
            end
            if (kind == 8) begin
                r = $urandom_range(3);
                for (int c = 0; c < 4; c++) mat[((r + 1) % 4) * 4 + c] = mat[r * 4 + c];
            end
            send_matrix();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (7000) @(posedge i_clk);
        $display("covered %0d matrices, %0d inverse words (%0d singular, %0d saturated)",
                 matrices_sent, result_count, singular_count, saturated_count);
        $display("load idling phases 0/73/28 percent, one drain pause mid-run");
        if (fail_count == 0 && pending_words == 0) begin
            $display("PASS matrix_inverse_4x4_unit");
        end else begin
            $display("FAIL matrix_inverse_4x4_unit");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/minv4x4_pkg.sv
src/minv4x4_ram.sv
src/matrix_inverse_4x4_unit.sv
dv/minv4x4_checker.sv
dv/tb_top.sv
